@@ design/tqig_pkg.sv @@
// Shared types, constants and register codes of the tile quad index generator.
`timescale 1ns / 1ps

package tqig_pkg;

   // Vertex index width of every emitted triangle corner.
   localparam int IDX_W = 13;

   localparam int TILE_SIZE_W = 7;
   localparam int EDGE_MASK_W = 4;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_TILE_SIZE_DEFAULT = 64;
   localparam int TILE_SIZE_MIN         = 4;

   localparam logic [TILE_SIZE_W-1:0] TILE_SIZE_RESET = 7'd32;
   localparam logic [EDGE_MASK_W-1:0] EDGE_MASK_RESET = 4'd0;

   // Depth of the descriptor queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_MASK = 1'b1;

   // Triangle pair codes, in emission order; they also index edge_mask.
   localparam logic [1:0] PAIR_TOP    = 2'd0;
   localparam logic [1:0] PAIR_LEFT   = 2'd1;
   localparam logic [1:0] PAIR_BOTTOM = 2'd2;
   localparam logic [1:0] PAIR_RIGHT  = 2'd3;

   typedef struct packed {
      logic [4:0] quad_col;
      logic [4:0] quad_row;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] vert_first;
      logic [IDX_W-1:0] vert_second;
      logic [IDX_W-1:0] vert_third;
      logic             last_tri;
   } rsp_type;

   // One classified quad: left column vertices of the three rows and the
   // pairs that collapse into a stitching triangle.
   typedef struct packed {
      logic [IDX_W-1:0] vert_a;
      logic [IDX_W-1:0] vert_d;
      logic [IDX_W-1:0] vert_g;
      logic [3:0]       stitch;
   } desc_type;

endpackage

@@ design/tqig_front.sv @@
// Front end: configuration registers and per-quad address and border classification.
`timescale 1ns / 1ps

module tqig_front #(
   parameter int MAX_TILE_SIZE = tqig_pkg::MAX_TILE_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [tqig_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tqig_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tqig_pkg::req_type                    req_data,
   output tqig_pkg::desc_type                   desc
);

   localparam int TW = $clog2(MAX_TILE_SIZE + 1);
   localparam int CW = (TW > tqig_pkg::TILE_SIZE_W) ? TW : tqig_pkg::TILE_SIZE_W;
   localparam int IW = tqig_pkg::IDX_W;

   logic [tqig_pkg::TILE_SIZE_W-1:0] tile_size_ff, tile_size_in;
   logic [tqig_pkg::EDGE_MASK_W-1:0] edge_mask_ff, edge_mask_in;

   logic [CW-1:0]   size_ext;
   logic [CW-1:0]   size_eff;
   logic [CW-1:0]   size_less2;
   logic [IW-1:0]   width_vtx;
   logic [IW-1:0]   row_prod;
   logic [5:0]      col2;
   logic [5:0]      row2;

   always_comb begin
      tile_size_in = tile_size_ff;
      edge_mask_in = edge_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            tqig_pkg::CSR_TILE_SIZE: tile_size_in = csr_wdata;
            tqig_pkg::CSR_EDGE_MASK: edge_mask_in = csr_wdata[tqig_pkg::EDGE_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff <= tqig_pkg::TILE_SIZE_RESET;
         edge_mask_ff <= tqig_pkg::EDGE_MASK_RESET;
      end else begin
         tile_size_ff <= tile_size_in;
         edge_mask_ff <= edge_mask_in;
      end
   end

   // Effective tile size is the register saturated to the supported range.
   always_comb begin
      size_ext = CW'(tile_size_ff);
      if (size_ext < CW'(tqig_pkg::TILE_SIZE_MIN)) begin
         size_eff = CW'(tqig_pkg::TILE_SIZE_MIN);
      end else if (size_ext > CW'(MAX_TILE_SIZE)) begin
         size_eff = CW'(MAX_TILE_SIZE);
      end else begin
         size_eff = size_ext;
      end
      size_less2 = size_eff - CW'(2);
   end

   always_comb begin
      col2      = {req_data.quad_col, 1'b0};
      row2      = {req_data.quad_row, 1'b0};
      width_vtx = IW'(size_eff) + IW'(1);
      row_prod  = IW'(row2) * width_vtx;
      desc.vert_a = row_prod + IW'(col2);
      desc.vert_d = desc.vert_a + width_vtx;
      desc.vert_g = desc.vert_d + width_vtx;
      desc.stitch[tqig_pkg::PAIR_TOP]    = (req_data.quad_row == 5'd0) && edge_mask_ff[0];
      desc.stitch[tqig_pkg::PAIR_LEFT]   = (req_data.quad_col == 5'd0) && edge_mask_ff[1];
      desc.stitch[tqig_pkg::PAIR_BOTTOM] = (CW'(row2) == size_less2) && edge_mask_ff[2];
      desc.stitch[tqig_pkg::PAIR_RIGHT]  = (CW'(col2) == size_less2) && edge_mask_ff[3];
   end

endmodule

@@ design/tqig_queue.sv @@
// Short descriptor queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module tqig_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tqig_pkg::desc_type wdata,
   output logic               full,
   input  logic               pop,
   output tqig_pkg::desc_type rdata,
   output logic               empty
);

   localparam int DEPTH = tqig_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   tqig_pkg::desc_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == NW'(0));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/tqig_back.sv @@
// Back end: walks the triangle pairs of one quad and emits one triangle per cycle unless the receiver stalls.
`timescale 1ns / 1ps

module tqig_back (
   input  logic               clock,
   input  logic               reset,
   input  tqig_pkg::desc_type q_data,
   input  logic               q_empty,
   output logic               q_pop,
   output tqig_pkg::rsp_type  rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop
);

   localparam int IW = tqig_pkg::IDX_W;

   tqig_pkg::desc_type cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [1:0]         pair_ff, pair_in;
   logic               sub_ff, sub_in;
   tqig_pkg::rsp_type  out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic             emit;
   logic             stitched;
   logic             pair_done;
   logic             last;
   logic             load;
   logic [IW-1:0]    vb, vc, ve, vf, vh, vi;
   tqig_pkg::rsp_type tri_now;

   assign stitched  = cur_ff.stitch[pair_ff];
   assign pair_done = stitched || sub_ff;
   assign last      = (pair_ff == tqig_pkg::PAIR_RIGHT) && pair_done;
   assign emit      = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign load      = !q_empty && (!cur_valid_ff || (emit && last));
   assign q_pop     = load;

   always_comb begin
      vb = cur_ff.vert_a + IW'(1);
      vc = cur_ff.vert_a + IW'(2);
      ve = cur_ff.vert_d + IW'(1);
      vf = cur_ff.vert_d + IW'(2);
      vh = cur_ff.vert_g + IW'(1);
      vi = cur_ff.vert_g + IW'(2);

      tri_now.last_tri   = last;
      tri_now.vert_third = ve;
      unique case (pair_ff)
         tqig_pkg::PAIR_TOP: begin
            if (stitched) begin
               tri_now.vert_first  = cur_ff.vert_a;
               tri_now.vert_second = ve;
               tri_now.vert_third  = vc;
            end else if (!sub_ff) begin
               tri_now.vert_first  = cur_ff.vert_a;
               tri_now.vert_second = ve;
               tri_now.vert_third  = vb;
            end else begin
               tri_now.vert_first  = vb;
               tri_now.vert_second = ve;
               tri_now.vert_third  = vc;
            end
         end
         tqig_pkg::PAIR_LEFT: begin
            if (stitched) begin
               tri_now.vert_first  = cur_ff.vert_a;
               tri_now.vert_second = cur_ff.vert_g;
            end else if (!sub_ff) begin
               tri_now.vert_first  = cur_ff.vert_a;
               tri_now.vert_second = cur_ff.vert_d;
            end else begin
               tri_now.vert_first  = cur_ff.vert_d;
               tri_now.vert_second = cur_ff.vert_g;
            end
         end
         tqig_pkg::PAIR_BOTTOM: begin
            if (stitched) begin
               tri_now.vert_first  = cur_ff.vert_g;
               tri_now.vert_second = vi;
            end else if (!sub_ff) begin
               tri_now.vert_first  = cur_ff.vert_g;
               tri_now.vert_second = vh;
            end else begin
               tri_now.vert_first  = vh;
               tri_now.vert_second = vi;
            end
         end
         default: begin
            if (stitched) begin
               tri_now.vert_first  = vi;
               tri_now.vert_second = vc;
            end else if (!sub_ff) begin
               tri_now.vert_first  = vi;
               tri_now.vert_second = vf;
            end else begin
               tri_now.vert_first  = vf;
               tri_now.vert_second = vc;
            end
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pair_in      = pair_ff;
      sub_in       = sub_ff;
      if (load) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         pair_in      = tqig_pkg::PAIR_TOP;
         sub_in       = 1'b0;
      end else if (emit && last) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         if (pair_done) begin
            pair_in = pair_ff + 2'd1;
            sub_in  = 1'b0;
         end else begin
            sub_in = 1'b1;
         end
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = tri_now;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pair_ff      <= tqig_pkg::PAIR_TOP;
         sub_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pair_ff      <= pair_in;
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

@@ design/tile_quad_index_generator_core.sv @@
// Top level of the tile quad index generator.
`timescale 1ns / 1ps
//
// Usage: each request transaction names one 2x2 quad cell of a square terrain
// tile by column and row. The block answers with that cell's triangles as
// vertex index triples, one response transaction per triangle, in the order
// top pair, left pair, bottom pair, right pair. A pair on the tile border
// whose edge_mask bit is set collapses into a single stitching triangle, so a
// quad gives four to eight triangles, and the last one carries last_tri.
// Requests enter through push/full; responses leave through empty/pop, where
// the oldest waiting triangle is shown while empty is low.
// The first triangle of a quad passes from the queue through the back end's
// current-quad register into the output register. Throughput: the back end
// sequencer emits one triangle per cycle while the receiver is not stalling;
// a two-entry descriptor queue lets requests be taken while the back end is
// busy, and full rises only when that queue holds two quads.
// When the receiver stalls, the output register holds its triangle, the
// sequencer stops, the queue fills and full then holds off new requests.
// Reset is synchronous: it empties the queue and the output register and
// returns tile_size to 32 and edge_mask to 0. Configuration writes take
// effect at the next edge and are meant for idle periods.

module tile_quad_index_generator_core #(
   parameter int MAX_TILE_SIZE = tqig_pkg::MAX_TILE_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  tqig_pkg::req_type                req_data,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output tqig_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [tqig_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tqig_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tqig_pkg::desc_type front_desc;
   tqig_pkg::desc_type head_desc;
   logic               q_empty;
   logic               q_pop;

   // Front end: turns a quad into its corner addresses and border flags.
   tqig_front #(
      .MAX_TILE_SIZE(MAX_TILE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .desc      (front_desc)
   );

   // The queue accepts a transaction whenever it is not full.
   tqig_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_desc),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (head_desc),
      .empty (q_empty)
   );

   // Back end: sequences the triangles and owns the output register.
   tqig_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (head_desc),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

@@ design/tqig_checker.sv @@
// Port-level assertions for the tile quad index generator, bound to the top level.
`timescale 1ns / 1ps

module tqig_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input tqig_pkg::rsp_type                rsp_data
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");

   // Reset leaves the request queue open.
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // A stalled response transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

   // The three corners of every triangle are distinct vertices.
   a_distinct: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.vert_first != rsp_data.vert_second &&
                      rsp_data.vert_first != rsp_data.vert_third &&
                      rsp_data.vert_second != rsp_data.vert_third))
      else $error("degenerate triangle emitted");

endmodule

bind tile_quad_index_generator_core tqig_checker u_tqig_checker (.*);
